### sv/pwtc_pkg.sv
// Shared types and constants for the proof-of-work target check block.
// No dependencies; imported by pwtc_cfg_regs and the top level.
`default_nettype none

package pwtc_pkg;

	localparam int unsigned TIME_W   = 64;
	localparam int unsigned HASH_W   = 256;
	localparam int unsigned LOG2_W   = 6;
	localparam int unsigned QUANT_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// retarget step is difficulty >> RETARGET_SHIFT (divide by 2048)
	localparam int unsigned RETARGET_SHIFT = 11;
	// lowest retarget factor is -FACTOR_FLOOR
	localparam logic [TIME_W-1:0] FACTOR_FLOOR = 64'd99;

	localparam logic [TIME_W-1:0]  END_TIME_RST = 64'd1672531199000;
	localparam logic [LOG2_W-1:0]  LOG2_RST     = 6'd24;
	localparam logic [QUANT_W-1:0] QUANT_RST    = 32'd7000;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ENDED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABOVE    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_END_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG2     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]  end_time;
		logic [LOG2_W-1:0]  init_log2;
		logic [QUANT_W-1:0] quantum;
	} cfg_t;

endpackage

`default_nettype wire

### sv/pwtc_cfg_regs.sv
// Configuration register file: end time, initial log2 difficulty, time quantum.
// Depends on pwtc_pkg.
`default_nettype none

module pwtc_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [pwtc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [pwtc_pkg::TIME_W-1:0]      wr_data,
	output pwtc_pkg::cfg_t                        cfg
);
	import pwtc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_time  <= END_TIME_RST;
			cfg_q.init_log2 <= LOG2_RST;
			cfg_q.quantum   <= QUANT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_END_TIME: cfg_q.end_time  <= wr_data;
				REG_LOG2:     cfg_q.init_log2 <= wr_data[LOG2_W-1:0];
				REG_QUANTUM:  cfg_q.quantum   <= wr_data[QUANT_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### sv/pwtc_addsub.sv
// Shared adder/subtractor used by every arithmetic step of the sequencer.
// No dependencies. cout is the carry out; on subtract it is high for a >= b.
`default_nettype none

module pwtc_addsub #(
	parameter int unsigned W = 256
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic [W-1:0]      sum,
	output logic              cout
);

	logic [W-1:0] b_eff;
	logic [W:0]   full;

	assign b_eff = sub ? ~b : b;
	assign full  = {1'b0, a} + {1'b0, b_eff} + (W+1)'(sub);
	assign sum   = full[W-1:0];
	assign cout  = full[W];

endmodule

`default_nettype wire

### sv/pow_target_check_difficulty_retarget_top.sv
// Top level of the proof-of-work target check with difficulty retarget.
// Depends on pwtc_pkg, pwtc_cfg_regs and pwtc_addsub.
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------
// input    | in_valid / in_stall    | hash_word3..hash_word0, block_time
// output   | out_valid / out_stall  | status, difficulty_low, target_high
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready tied high)
//
// Every arithmetic step runs through one NUM_BITS-wide add/sub unit. An accepted
// (status 0) transaction runs a 64-step time division, a 64-step shift-add
// multiply and a NUM_BITS-step target division; rejected and ended ones go
// straight to the result. The first transaction after reset also runs a target
// division for the initial target.
// Reset clears the sequencer, the started flag and the output valid; config
// registers go to their defaults. in_stall is high while a transaction is in work.
// The output register frees the sequencer: the next input transaction is taken
// while a result waits under out_stall, and only the final handoff waits.

module pow_target_check_difficulty_retarget_top #(
	parameter int unsigned NUM_BITS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input transactions
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] hash_word3,
	input  wire logic [63:0] hash_word2,
	input  wire logic [63:0] hash_word1,
	input  wire logic [63:0] hash_word0,
	input  wire logic [63:0] block_time,
	// result transactions
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [63:0]      difficulty_low,
	output logic [63:0]      target_high,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [pwtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0] cfg_data
);
	import pwtc_pkg::*;

	localparam int unsigned NB = NUM_BITS;
	localparam int unsigned CW = $clog2(NUM_BITS);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DINIT  = 10'b00_0000_0010,  // zero check, start target division
		S_DDIV   = 10'b00_0000_0100,  // all-ones / difficulty, one bit a cycle
		S_CHECK  = 10'b00_0000_1000,  // status, elapsed time
		S_TDIV   = 10'b00_0001_0000,  // elapsed / quantum, one bit a cycle
		S_FACTOR = 10'b00_0010_0000,  // f = 1 - quotient
		S_NEGATE = 10'b00_0100_0000,  // magnitude, floor at -99
		S_MUL    = 10'b00_1000_0000,  // step * magnitude, shift-add
		S_UPDATE = 10'b01_0000_0000,  // difficulty +/- product
		S_DONE   = 10'b10_0000_0000   // hand result to output register
	} state_t;

	cfg_t cfg;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              started_q;
	logic              init_q;     // target division belongs to first-use load
	logic              neg_q;

	logic [NB-1:0]     diff_q;
	logic [NB-1:0]     tgt_q;
	logic [NB-1:0]     rem_q;
	logic [NB-1:0]     quo_q;
	logic [NB-1:0]     step_q;
	logic [NB-1:0]     prod_q;
	logic [HASH_W-1:0] hash_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] mag_q;
	logic [STATUS_W-1:0] status_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [63:0]         out_diff_q;
	logic [63:0]         out_tgt_q;

	// shared unit
	logic [NB-1:0] au_a, au_b, au_sum;
	logic          au_sub, au_cout;

	logic [QUANT_W:0] rem_sh_t;    // time division partial remainder, shifted
	logic [NB-1:0]    rem_sh_d;    // target division partial remainder, shifted
	logic             take_d;
	logic [TIME_W-1:0] neg_mag;
	logic             out_free;

	pwtc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pwtc_addsub #(.W(NB)) u_au (
		.a    (au_a),
		.b    (au_b),
		.sub  (au_sub),
		.sum  (au_sum),
		.cout (au_cout)
	);

	assign rem_sh_t = {rem_q[QUANT_W-1:0], quo_q[TIME_W-1]};
	assign rem_sh_d = {rem_q[NB-2:0], 1'b1};   // dividend is all ones
	assign take_d   = rem_q[NB-1] | au_cout;
	assign neg_mag  = (au_sum[TIME_W-1:0] > FACTOR_FLOOR) ? FACTOR_FLOOR
	                                                      : au_sum[TIME_W-1:0];
	assign out_free = !out_valid_q || !out_stall;

	// operand selection for the shared unit
	always_comb begin
		au_a   = '0;
		au_b   = '0;
		au_sub = 1'b1;
		case (state_q)
			S_CHECK: begin
				au_a = NB'(now_q);
				au_b = NB'(last_time_q);
			end
			S_TDIV: begin
				au_a = NB'(rem_sh_t);
				au_b = NB'(cfg.quantum);
			end
			S_FACTOR: begin
				au_a = NB'(64'd1);
				au_b = NB'(quo_q[TIME_W-1:0]);
			end
			S_NEGATE: begin
				au_b = NB'(mag_q);
			end
			S_MUL: begin
				au_a   = prod_q;
				au_b   = step_q;
				au_sub = 1'b0;
			end
			S_UPDATE: begin
				au_a   = diff_q;
				au_b   = prod_q;
				au_sub = neg_q;
			end
			S_DDIV: begin
				au_a = rem_sh_d;
				au_b = diff_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!started_q) begin
							started_q <= 1'b1;
							init_q    <= 1'b1;
							state_q   <= S_DINIT;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_DINIT: begin
					cnt_q <= CW'(NB - 1);
					if (diff_q == '0)
						state_q <= init_q ? S_CHECK : S_DONE;
					else
						state_q <= S_DDIV;
				end
				S_DDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= init_q ? S_CHECK : S_DONE;
				end
				S_CHECK: begin
					init_q <= 1'b0;
					cnt_q  <= CW'(TIME_W - 1);
					if (now_q > cfg.end_time || hash_q > HASH_W'(tgt_q))
						state_q <= S_DONE;
					else
						state_q <= S_TDIV;
				end
				S_TDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_FACTOR;
				end
				S_FACTOR: state_q <= S_NEGATE;
				S_NEGATE: begin
					cnt_q   <= CW'(TIME_W - 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_UPDATE;
				end
				S_UPDATE: state_q <= S_DINIT;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					hash_q <= {hash_word3, hash_word2, hash_word1, hash_word0};
					now_q  <= block_time;
					if (!started_q) begin
						diff_q      <= NB'(1) << cfg.init_log2;
						last_time_q <= block_time;
					end
				end
			end
			S_DINIT: begin
				rem_q <= '0;
				if (diff_q == '0)
					tgt_q <= '1;
			end
			S_DDIV: begin
				rem_q <= take_d ? au_sum : rem_sh_d;
				quo_q <= {quo_q[NB-2:0], take_d};
				if (cnt_q == '0)
					tgt_q <= {quo_q[NB-2:0], take_d};
			end
			S_CHECK: begin
				// elapsed time wraps; it becomes the time division's dividend
				quo_q <= NB'(au_sum[TIME_W-1:0]);
				rem_q <= '0;
				if (now_q > cfg.end_time)
					status_q <= STATUS_ENDED;
				else if (hash_q > HASH_W'(tgt_q))
					status_q <= STATUS_ABOVE;
				else
					status_q <= STATUS_ACCEPTED;
			end
			S_TDIV: begin
				// zero quantum always subtracts, giving an all-ones quotient
				rem_q <= NB'(au_cout ? au_sum[QUANT_W:0] : rem_sh_t);
				quo_q <= NB'({quo_q[TIME_W-2:0], au_cout});
			end
			S_FACTOR: begin
				mag_q <= au_sum[TIME_W-1:0];
				neg_q <= au_sum[TIME_W-1];
			end
			S_NEGATE: begin
				if (neg_q)
					mag_q <= neg_mag;
				step_q <= diff_q >> RETARGET_SHIFT;
				prod_q <= '0;
			end
			S_MUL: begin
				if (mag_q[0])
					prod_q <= au_sum;
				step_q <= step_q << 1;
				mag_q  <= mag_q >> 1;
			end
			S_UPDATE: begin
				diff_q      <= au_sum;
				last_time_q <= now_q;
			end
			S_DONE: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_diff_q   <= diff_q[63:0];
					out_tgt_q    <= tgt_q[NB-1 -: 64];
				end
			end
			default: ;
		endcase
	end

	assign in_stall       = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign difficulty_low = out_diff_q;
	assign target_high    = out_tgt_q;

endmodule

`default_nettype wire
